FILE: sv/oes_pkg.sv
`default_nettype none
package oes_pkg;

  typedef struct packed {
    logic               chan;
    logic signed [15:0] sample;
  } oes_in_t;

  typedef struct packed {
    logic        out_chan;
    logic [30:0] slope;
  } oes_out_t;

  // configuration register indexes
  localparam logic [2:0] CFG_B0 = 3'd0;
  localparam logic [2:0] CFG_B1 = 3'd1;
  localparam logic [2:0] CFG_B2 = 3'd2;
  localparam logic [2:0] CFG_A1 = 3'd3;
  localparam logic [2:0] CFG_A2 = 3'd4;

  // operand selects for the shared multiplier
  localparam logic [2:0] MUL_B0 = 3'd0;
  localparam logic [2:0] MUL_B1 = 3'd1;
  localparam logic [2:0] MUL_B2 = 3'd2;
  localparam logic [2:0] MUL_A1 = 3'd3;
  localparam logic [2:0] MUL_A2 = 3'd4;

  localparam logic signed [63:0] Y_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] Y_MIN   = 64'shFFFF_FFFF_8000_0000;
  localparam logic signed [63:0] MEM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam logic signed [63:0] MEM_MIN = 64'shFFFF_8000_0000_0000;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [2:0] mul_sel;
    logic       ld_y;
    logic       ld_acc1;
    logic       ld_acc2;
    logic       wr_mem1;
    logic       fin;
  } oes_cmd_t;

  function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
    logic signed [47:0] r;
    if (v > MEM_MAX) begin
      r = 48'sh7FFF_FFFF_FFFF;
    end else if (v < MEM_MIN) begin
      r = 48'sh8000_0000_0000;
    end else begin
      r = v[47:0];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > Y_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < Y_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/onset_envelope_slope_core.sv
`default_nettype none
// channel   direction  handshake            payload
// in_       input      in_valid / in_stall   oes_in_t  {chan, sample}
// out_      output     out_valid / out_stall oes_out_t {out_chan, slope}
// cfg_      input      cfg_we                cfg_index, cfg_data (coefficients)
//
// One item holds the sequencer through the accept, five multiply steps and the
// result step. The result register and out_valid are loaded at the result step,
// as the sequencer returns to idle to take the next item. One 32x32 multiplier is
// shared over the five products of the biquad, one product per cycle.
// Synchronous active-low reset clears coefficients, filter memories and previous values.
// The next item is taken while a result waits; a stalled result holds the
// sequencer only at its final step.
module onset_envelope_slope_core #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire oes_pkg::oes_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output oes_pkg::oes_out_t      out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data
);
  import oes_pkg::*;

  oes_cmd_t cmd;

  oes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  oes_datapath #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sv/oes_ctrl.sv
`default_nettype none
module oes_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output oes_pkg::oes_cmd_t      cmd
);
  import oes_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_B0   = 3'd1;
  localparam logic [2:0] S_Y    = 3'd2;
  localparam logic [2:0] S_B1   = 3'd3;
  localparam logic [2:0] S_B2   = 3'd4;
  localparam logic [2:0] S_A1   = 3'd5;
  localparam logic [2:0] S_A2   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       can_fin;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // result register frees up this cycle or is already empty
  assign can_fin   = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_B0;
        end
      end
      S_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B0;
        state_nxt   = S_Y;
      end
      S_Y: begin
        cmd.ld_y    = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B1;
        state_nxt   = S_B1;
      end
      S_B1: begin
        cmd.ld_acc1 = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_B2;
        state_nxt   = S_B2;
      end
      S_B2: begin
        cmd.ld_acc2 = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A1;
        state_nxt   = S_A1;
      end
      S_A1: begin
        cmd.wr_mem1 = 1'b1;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_A2;
        state_nxt   = S_A2;
      end
      S_A2: begin
        if (can_fin) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.fin) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: sv/oes_datapath.sv
`default_nettype none
module oes_datapath #(
  parameter int NUM_CHANNELS = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire oes_pkg::oes_in_t  in_data,
  input  wire oes_pkg::oes_cmd_t cmd,
  output oes_pkg::oes_out_t      out_data
);
  import oes_pkg::*;

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic signed [31:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  logic signed [47:0] mem_one_r [NUM_CHANNELS];
  logic signed [47:0] mem_two_r [NUM_CHANNELS];
  logic signed [31:0] prev_r    [NUM_CHANNELS];

  logic               chan_r;
  logic               hit_r;
  logic [IDX_W-1:0]   idx_r;
  logic [15:0]        x_r;
  logic signed [63:0] prod_r;
  logic signed [31:0] y_r;
  logic signed [63:0] acc1_r;
  logic signed [63:0] acc2_r;
  oes_out_t           out_r;

  logic signed [16:0] s_ext;
  logic signed [16:0] s_mag;
  logic               in_hit;
  logic signed [31:0] op_a;
  logic signed [31:0] op_b;
  logic signed [63:0] acc0;
  logic signed [63:0] fb_term;
  logic signed [47:0] mem1_new;
  logic signed [47:0] mem2_new;
  logic signed [32:0] diff;
  logic [30:0]        slope_new;

  assign s_ext  = 17'(in_data.sample);
  assign s_mag  = s_ext[16] ? -s_ext : s_ext;
  assign in_hit = (32'(in_data.chan) < 32'(NUM_CHANNELS));

  always_comb begin
    op_a = b0_r;
    op_b = signed'({16'b0, x_r});
    unique case (cmd.mul_sel)
      MUL_B0: op_a = b0_r;
      MUL_B1: op_a = b1_r;
      MUL_B2: op_a = b2_r;
      MUL_A1: begin
        op_a = a1_r;
        op_b = y_r;
      end
      MUL_A2: begin
        op_a = a2_r;
        op_b = y_r;
      end
      default: op_a = b0_r;
    endcase
  end

  // acc0 holds 44 fractional bits; y keeps 31
  assign acc0     = prod_r + 64'(mem_one_r[idx_r]);
  assign fb_term  = prod_r >>> 16;
  assign mem1_new = sat48(acc1_r - fb_term);
  assign mem2_new = sat48(acc2_r - fb_term);
  assign diff     = 33'(y_r) - 33'(prev_r[idx_r]);

  always_comb begin
    if (diff[32]) begin
      slope_new = '0;
    end else if (diff[31]) begin
      slope_new = '1;
    end else begin
      slope_new = diff[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= '0;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_B0:  b0_r <= cfg_data;
        CFG_B1:  b1_r <= cfg_data;
        CFG_B2:  b2_r <= cfg_data;
        CFG_A1:  a1_r <= cfg_data;
        CFG_A2:  a2_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mem_one_r[i] <= '0;
        mem_two_r[i] <= '0;
        prev_r[i]    <= '0;
      end
    end else begin
      if (cmd.wr_mem1 && hit_r) begin
        mem_one_r[idx_r] <= mem1_new;
      end
      if (cmd.fin && hit_r) begin
        mem_two_r[idx_r] <= mem2_new;
        prev_r[idx_r]    <= y_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_r <= in_data.chan;
      hit_r  <= in_hit;
      // out-of-range channel still runs through, but reads entry 0 and writes nothing
      idx_r  <= in_hit ? IDX_W'(in_data.chan) : '0;
      x_r    <= s_mag[15:0];
    end
    if (cmd.mul_en) begin
      prod_r <= op_a * op_b;
    end
    if (cmd.ld_y) begin
      y_r <= sat32(acc0 >>> 13);
    end
    if (cmd.ld_acc1) begin
      acc1_r <= prod_r + 64'(mem_two_r[idx_r]);
    end
    if (cmd.ld_acc2) begin
      acc2_r <= prod_r;
    end
    if (cmd.fin) begin
      out_r.out_chan <= chan_r;
      out_r.slope    <= hit_r ? slope_new : '0;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire
